// ----- rtl/gbsd_pkg.sv -----
// gbsd_pkg: shared types and constants of the genotype byte-stream decoder
// no dependencies; imported by every module under rtl

`timescale 1ns / 1ps

package gbsd_pkg;

    localparam int unsigned NumIndW = 16;
    localparam int unsigned NumSnpW = 24;
    localparam int unsigned CfgDataW = 24;

    localparam logic [7:0] Magic0Byte = 8'h6C;
    localparam logic [7:0] Magic1Byte = 8'h1B;
    localparam logic [7:0] SnpMajorByte = 8'h01;

    // register indexes of the configuration port
    localparam logic CfgNumIndividuals = 1'b0;
    localparam logic CfgNumSnps = 1'b1;

    // result status codes
    localparam logic [1:0] StGenotype = 2'd0;
    localparam logic [1:0] StBadMagic = 2'd1;
    localparam logic [1:0] StBadOrder = 2'd2;

    // 2-bit pair recoding, lowest pair first
    localparam logic [1:0] GenoMap [4] = '{2'd0, 2'd2, 2'd1, 2'd3};

    // one request from the front end to the back end: a byte of genotypes or an error
    typedef struct packed {
        logic [7:0]         data_byte;
        logic [NumIndW-1:0] ind_base;
        logic [NumSnpW-1:0] snp;
        logic [1:0]         last_k;
        logic [1:0]         status;
    } job_t;

endpackage

// ----- rtl/gbsd_front.sv -----
// gbsd_front: header check, configuration registers and per-byte classification
// depends on gbsd_pkg

`timescale 1ns / 1ps

module gbsd_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic                    cfg_addr,
    input  logic [gbsd_pkg::CfgDataW-1:0] cfg_wdata,
    input  logic                    accept,
    input  logic [7:0]              data_byte,
    input  logic                    start_of_file,
    output logic                    job_valid,
    output gbsd_pkg::job_t          job
);
    import gbsd_pkg::*;

    typedef enum logic [4:0] {
        PH_MAGIC0 = 5'b00001,
        PH_MAGIC1 = 5'b00010,
        PH_ORDER  = 5'b00100,
        PH_DATA   = 5'b01000,
        PH_HALT   = 5'b10000
    } phase_t;

    phase_t             phase_reg, phase_next, phase_eff;
    logic [NumIndW-1:0] num_ind_reg;
    logic [NumSnpW-1:0] num_snp_reg;
    logic [NumIndW-1:0] ind_reg, ind_next, ind_eff;
    logic [NumSnpW-1:0] snp_reg, snp_next, snp_eff, snp_inc;
    logic [NumIndW:0]   ind_plus4;
    logic [3:0]         pair_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_ind_reg <= NumIndW'(1);
            num_snp_reg <= NumSnpW'(1);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CfgNumIndividuals: num_ind_reg <= cfg_wdata[NumIndW-1:0];
                CfgNumSnps:        num_snp_reg <= cfg_wdata[NumSnpW-1:0];
                default:           ;
            endcase
        end
    end

    assign phase_eff = start_of_file ? PH_MAGIC0 : phase_reg;
    assign ind_eff   = start_of_file ? '0 : ind_reg;
    assign snp_eff   = start_of_file ? '0 : snp_reg;

    assign ind_plus4 = {1'b0, ind_eff} + (NumIndW+1)'(4);
    assign snp_inc   = snp_eff + NumSnpW'(1);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            pair_ok[k] = ({1'b0, ind_eff} + (NumIndW+1)'(k)) < {1'b0, num_ind_reg};
        end
    end

    always_comb begin
        phase_next     = phase_eff;
        ind_next       = ind_eff;
        snp_next       = snp_eff;
        job_valid      = 1'b0;
        job.data_byte  = '0;
        job.ind_base   = '0;
        job.snp        = '0;
        job.last_k     = '0;
        job.status     = StGenotype;
        case (phase_eff)
            PH_MAGIC0: begin
                if (data_byte != Magic0Byte) begin
                    job_valid  = 1'b1;
                    job.status = StBadMagic;
                    phase_next = PH_HALT;
                end else begin
                    phase_next = PH_MAGIC1;
                end
            end
            PH_MAGIC1: begin
                if (data_byte != Magic1Byte) begin
                    job_valid  = 1'b1;
                    job.status = StBadMagic;
                    phase_next = PH_HALT;
                end else begin
                    phase_next = PH_ORDER;
                end
            end
            PH_ORDER: begin
                if (data_byte != SnpMajorByte) begin
                    job_valid  = 1'b1;
                    job.status = StBadOrder;
                    phase_next = PH_HALT;
                end else begin
                    ind_next   = '0;
                    snp_next   = '0;
                    phase_next = (num_snp_reg == '0) ? PH_HALT : PH_DATA;
                end
            end
            PH_DATA: begin
                job_valid     = pair_ok[0];
                job.data_byte = data_byte;
                job.ind_base  = ind_eff;
                job.snp       = snp_eff;
                // pairs past the individual count are padding
                job.last_k    = pair_ok[3] ? 2'd3 : pair_ok[2] ? 2'd2 :
                                pair_ok[1] ? 2'd1 : 2'd0;
                if (ind_plus4 >= {1'b0, num_ind_reg}) begin
                    ind_next = '0;
                    snp_next = snp_inc;
                    if (snp_inc >= num_snp_reg) begin
                        phase_next = PH_HALT;
                    end
                end else begin
                    ind_next = ind_plus4[NumIndW-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_MAGIC0;
            ind_reg   <= '0;
            snp_reg   <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            ind_reg   <= ind_next;
            snp_reg   <= snp_next;
        end
    end

endmodule

// ----- rtl/gbsd_queue.sv -----
// gbsd_queue: two-entry request queue between front and back end
// depends on gbsd_pkg

`timescale 1ns / 1ps

module gbsd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  gbsd_pkg::job_t push_job,
    input  logic           pop,
    output logic           full,
    output logic           empty,
    output gbsd_pkg::job_t head
);
    import gbsd_pkg::*;

    job_t       slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

// ----- rtl/gbsd_back.sv -----
// gbsd_back: a request's results, one per cycle unless stalled, into the output register
// depends on gbsd_pkg

`timescale 1ns / 1ps

module gbsd_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_empty,
    input  gbsd_pkg::job_t q_head,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [1:0]     m_genotype,
    output logic [gbsd_pkg::NumIndW-1:0] m_individual_index,
    output logic [gbsd_pkg::NumSnpW-1:0] m_snp_index,
    output logic [1:0]     m_status,
    output logic           m_last_of_byte
);
    import gbsd_pkg::*;

    job_t               job_reg;
    logic               job_valid_reg;
    logic [1:0]         k_reg;
    logic               out_valid_reg;
    logic [1:0]         geno_reg;
    logic [NumIndW-1:0] ind_reg;
    logic [NumSnpW-1:0] snp_reg;
    logic [1:0]         status_reg;
    logic               last_reg;
    logic               out_load, is_last;
    logic [1:0]         pair;

    assign out_load = job_valid_reg && (!out_valid_reg || m_ready);
    assign is_last  = (k_reg == job_reg.last_k);
    assign q_pop    = !q_empty && (!job_valid_reg || (out_load && is_last));
    assign pair     = 2'(job_reg.data_byte >> {k_reg, 1'b0});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            k_reg         <= 2'd0;
        end else if (q_pop) begin
            job_valid_reg <= 1'b1;
            k_reg         <= 2'd0;
        end else if (out_load) begin
            job_valid_reg <= !is_last;
            k_reg         <= k_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg <= q_head;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            // error requests carry zero fields, so only the genotype needs masking
            geno_reg   <= (job_reg.status == StGenotype) ? GenoMap[pair] : 2'd0;
            ind_reg    <= job_reg.ind_base + NumIndW'(k_reg);
            snp_reg    <= job_reg.snp;
            status_reg <= job_reg.status;
            last_reg   <= is_last;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_genotype         = geno_reg;
    assign m_individual_index = ind_reg;
    assign m_snp_index        = snp_reg;
    assign m_status           = status_reg;
    assign m_last_of_byte     = last_reg;

endmodule

// ----- rtl/genotype_bed_stream_decoder.sv -----
// genotype_bed_stream_decoder: top level, byte stream in, genotype results out
// depends on gbsd_pkg, gbsd_front, gbsd_queue, gbsd_back
//
// channel   direction  handshake            payload
// s_        in         s_valid / s_ready    s_data_byte, s_start_of_file
// m_        out        m_valid / m_ready    m_genotype, m_individual_index, m_snp_index,
//                                           m_status, m_last_of_byte
// cfg_      in         cfg_wr_en            cfg_addr, cfg_wdata
//
// back end: one result per cycle unless stalled; a byte with n valid pairs gives n results
// good header bytes and bytes that yield nothing stay in the front end only
// a two-request queue lets the front keep taking bytes while the back end drains
// s_ready drops only when that queue is full; m_ready low stalls the back end alone
// reset is synchronous, active low; both counts reset to one

`timescale 1ns / 1ps

module genotype_bed_stream_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [gbsd_pkg::CfgDataW-1:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_start_of_file,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_genotype,
    output logic [gbsd_pkg::NumIndW-1:0] m_individual_index,
    output logic [gbsd_pkg::NumSnpW-1:0] m_snp_index,
    output logic [1:0]  m_status,
    output logic        m_last_of_byte
);
    import gbsd_pkg::*;

    logic accept, job_valid, q_full, q_empty, q_pop;
    job_t job, q_head;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    gbsd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .accept        (accept),
        .data_byte     (s_data_byte),
        .start_of_file (s_start_of_file),
        .job_valid     (job_valid),
        .job           (job)
    );

    gbsd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (accept && job_valid),
        .push_job (job),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (q_head)
    );

    gbsd_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .q_empty            (q_empty),
        .q_head             (q_head),
        .q_pop              (q_pop),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_genotype         (m_genotype),
        .m_individual_index (m_individual_index),
        .m_snp_index        (m_snp_index),
        .m_status           (m_status),
        .m_last_of_byte     (m_last_of_byte)
    );

    // an error is always a single result
    a_error_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != StGenotype) |-> m_last_of_byte)
        else $error("error result not marked last of byte");

    // error results carry zero genotype and indexes
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != StGenotype) |->
        (m_genotype == 2'd0 && m_individual_index == '0 && m_snp_index == '0))
        else $error("error result with non-zero fields");

    // the results of one byte follow each other without a gap
    a_byte_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_of_byte) |=> m_valid)
        else $error("gap inside the results of one byte");

    // nothing is taken in while the queue is full
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !accept)
        else $error("byte accepted with full queue");

endmodule

// ----- bench/gbsd_checker.sv -----
// gbsd_checker: watches both channels and the register port of the genotype decoder
// predicts every genotype or error result and compares it with what leaves the block
// depends on gbsd_pkg

`timescale 1ns / 1ps

module gbsd_checker
    import gbsd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_addr,
    input  logic [CfgDataW-1:0] cfg_wdata,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [7:0]          s_data_byte,
    input  logic                s_start_of_file,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [1:0]          m_genotype,
    input  logic [NumIndW-1:0]  m_individual_index,
    input  logic [NumSnpW-1:0]  m_snp_index,
    input  logic [1:0]          m_status,
    input  logic                m_last_of_byte,
    output int                  fail_count,
    output int                  outstanding
);

    typedef enum logic [2:0] {
        PhMagic0,
        PhMagic1,
        PhOrder,
        PhData,
        PhHalt
    } unpack_phase_e;

    typedef struct packed {
        logic [1:0]         genotype;
        logic [NumIndW-1:0] ind;
        logic [NumSnpW-1:0] snp;
        logic [1:0]         status;
        logic               last;
    } geno_result_t;

    geno_result_t       pending_genotypes[$];
    logic [NumIndW-1:0] num_ind;
    logic [NumSnpW-1:0] num_snps;
    unpack_phase_e      phase;
    logic [NumIndW-1:0] ind_count;
    logic [NumSnpW-1:0] snp_count;

    initial begin
        fail_count = 0;
        outstanding = 0;
    end

    // pair codes 1 and 2 swap, 0 and 3 stay
    function automatic logic [1:0] recode_pair(input logic [1:0] pair);
        case (pair)
            2'd1: return 2'd2;
            2'd2: return 2'd1;
            default: return pair;
        endcase
    endfunction

    task automatic push_error(input logic [1:0] st);
        geno_result_t r;
        r = '{genotype: 2'd0, ind: '0, snp: '0, status: st, last: 1'b1};
        pending_genotypes.push_back(r);
        phase = PhHalt;
    endtask

    task automatic unpack_byte(input logic [7:0] b, input logic sof);
        geno_result_t r;
        int span;
        int n;
        int nxt;
        if (sof) begin
            phase = PhMagic0;
            ind_count = '0;
            snp_count = '0;
        end
        case (phase)
            PhMagic0: begin
                if (b != Magic0Byte) push_error(StBadMagic);
                else phase = PhMagic1;
            end
            PhMagic1: begin
                if (b != Magic1Byte) push_error(StBadMagic);
                else phase = PhOrder;
            end
            PhOrder: begin
                if (b != SnpMajorByte) begin
                    push_error(StBadOrder);
                end else begin
                    ind_count = '0;
                    snp_count = '0;
                    phase = (num_snps == '0) ? PhHalt : PhData;
                end
            end
            PhData: begin
                // padding pairs past the individual count are dropped
                span = int'(num_ind) - int'(ind_count);
                n = (span > 4) ? 4 : ((span < 0) ? 0 : span);
                for (int k = 0; k < n; k++) begin
                    r.genotype = recode_pair(b[2*k +: 2]);
                    r.ind = ind_count + NumIndW'(k);
                    r.snp = snp_count;
                    r.status = StGenotype;
                    r.last = (k == n - 1);
                    pending_genotypes.push_back(r);
                end
                nxt = int'(ind_count) + 4;
                if (nxt >= int'(num_ind)) begin
                    ind_count = '0;
                    snp_count = snp_count + 1'b1;
                    if (snp_count >= num_snps) phase = PhHalt;
                end else begin
                    ind_count = nxt[NumIndW-1:0];
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        geno_result_t got;
        geno_result_t want;
        if (!aresetn) begin
            num_ind = NumIndW'(1);
            num_snps = NumSnpW'(1);
            phase = PhMagic0;
            ind_count = '0;
            snp_count = '0;
            pending_genotypes.delete();
        end else begin
            // predictions first so a same-edge result still finds its entry
            if (s_valid && s_ready) unpack_byte(s_data_byte, s_start_of_file);
            if (cfg_wr_en) begin
                if (cfg_addr == CfgNumIndividuals) num_ind = cfg_wdata[NumIndW-1:0];
                else num_snps = cfg_wdata[NumSnpW-1:0];
            end
            if (m_valid && m_ready) begin
                got = '{genotype: m_genotype, ind: m_individual_index, snp: m_snp_index,
                        status: m_status, last: m_last_of_byte};
                if (pending_genotypes.size() == 0) begin
                    $display("%0t: unexpected result geno %0d ind %0d snp %0d st %0d last %0b",
                             $time, got.genotype, got.ind, got.snp, got.status, got.last);
                    fail_count++;
                end else begin
                    want = pending_genotypes.pop_front();
                    if (got !== want) begin
                        $display({"%0t: mismatch expected geno %0d ind %0d snp %0d st %0d ",
                                  "last %0b, actual geno %0d ind %0d snp %0d st %0d last %0b"},
                                 $time, want.genotype, want.ind, want.snp, want.status,
                                 want.last, got.genotype, got.ind, got.snp, got.status,
                                 got.last);
                        fail_count++;
                    end
                end
            end
        end
        outstanding = pending_genotypes.size();
    end

endmodule

// ----- bench/tb.sv -----
// tb: top of the genotype decoder bench, drives byte streams and register writes
// depends on gbsd_pkg, genotype_bed_stream_decoder and gbsd_checker

`timescale 1ns / 1ps

module tb;
    import gbsd_pkg::*;

    localparam int CycleLimit = 400000;
    localparam int HoldOffCycles = 300;
    localparam int DrainCycles = 24;
    localparam int SectionItems = 65;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic                cfg_addr = CfgNumIndividuals;
    logic [CfgDataW-1:0] cfg_wdata = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [7:0]          s_data_byte = 8'h00;
    logic                s_start_of_file = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [1:0]          m_genotype;
    logic [NumIndW-1:0]  m_individual_index;
    logic [NumSnpW-1:0]  m_snp_index;
    logic [1:0]          m_status;
    logic                m_last_of_byte;

    int fail_count;
    int outstanding;
    int tx_idle_pct = 26;
    int rx_idle_pct = 58;
    int hold_off_req = 0;
    int item_budget = 0;
    int cur_ind = 1;
    int cur_snps = 1;

    always #5 aclk = ~aclk;

    genotype_bed_stream_decoder uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .s_start_of_file    (s_start_of_file),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_genotype         (m_genotype),
        .m_individual_index (m_individual_index),
        .m_snp_index        (m_snp_index),
        .m_status           (m_status),
        .m_last_of_byte     (m_last_of_byte)
    );

    gbsd_checker u_check (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .s_start_of_file    (s_start_of_file),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_genotype         (m_genotype),
        .m_individual_index (m_individual_index),
        .m_snp_index        (m_snp_index),
        .m_status           (m_status),
        .m_last_of_byte     (m_last_of_byte),
        .fail_count         (fail_count),
        .outstanding        (outstanding)
    );

    // result side: random back-pressure, or a long hold-off when asked
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_req != 0) begin
                hold_off_req = 0;
                m_ready <= 1'b0;
                repeat (HoldOffCycles) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        repeat (CycleLimit) @(posedge aclk);
        $display("tb failed");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic sof);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_start_of_file <= sof;
        do @(posedge aclk); while (!s_ready);
    endtask

    // wait until every predicted result has left, plus slack for bytes with no result
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    task automatic write_config(input logic [NumIndW-1:0] ind, input logic [NumSnpW-1:0] snps);
        cfg_wr_en <= 1'b1;
        cfg_addr <= CfgNumIndividuals;
        cfg_wdata <= CfgDataW'(ind);
        @(posedge aclk);
        cfg_addr <= CfgNumSnps;
        cfg_wdata <= CfgDataW'(snps);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_ind = ind;
        cur_snps = snps;
    endtask

    task automatic send_header(input logic sof);
        send_byte(Magic0Byte, sof);
        send_byte(Magic1Byte, 1'b0);
        send_byte(SnpMajorByte, 1'b0);
    endtask

    task automatic random_file();
        logic [7:0] hdr[3];
        int pick;
        int n;
        int p;
        int extra;
        hdr = '{Magic0Byte, Magic1Byte, SnpMajorByte};
        pick = $urandom_range(99);
        n = ((cur_ind + 3) / 4) * cur_snps;
        if (n > 40) n = 40;
        if (pick < 8) begin
            // carry on the current stream with no new header
            n = (cur_ind + 3) / 4;
            if (n > 40) n = 40;
            repeat (n) send_byte(8'($urandom_range(255)), 1'b0);
            item_budget -= n;
        end else if (pick < 78) begin
            send_header($urandom_range(9) != 0);
            repeat (n) send_byte(8'($urandom_range(255)), 1'b0);
            // trailing bytes past the last snp, unless the file was cut at 40 bytes
            extra = $urandom_range(2);
            repeat (extra) send_byte(8'($urandom_range(255)), 1'b0);
            item_budget -= n + 3 + extra;
        end else if (pick < 90) begin
            // header broken at one byte, order byte often individual-major
            p = $urandom_range(2);
            if (p == 2 && $urandom_range(1) == 0) hdr[2] = 8'h00;
            else hdr[p] = hdr[p] ^ 8'($urandom_range(255, 1));
            for (int i = 0; i <= p; i++) send_byte(hdr[i], i == 0);
            send_byte(8'($urandom_range(255)), 1'b0);
            item_budget -= p + 2;
        end else begin
            extra = $urandom_range(4, 1);
            repeat (extra) send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
            item_budget -= extra;
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // stream without a start flag after reset, then bytes after the last snp
        send_header(1'b0);
        send_byte(8'hE4, 1'b0);
        send_byte(8'hFF, 1'b0);
        // wrong first magic, then halted
        send_byte(8'h00, 1'b1);
        send_byte(Magic0Byte, 1'b0);
        // wrong second magic
        send_byte(Magic0Byte, 1'b1);
        send_byte(8'h1A, 1'b0);
        // individual-major order
        send_byte(Magic0Byte, 1'b1);
        send_byte(Magic1Byte, 1'b0);
        send_byte(8'h00, 1'b0);

        settle();
        write_config(NumIndW'(5), NumSnpW'(2));
        send_header(1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h1B, 1'b0);
        send_byte(8'hE4, 1'b0);

        // zero individuals: each byte is a whole snp with nothing out
        settle();
        write_config('0, NumSnpW'(2));
        send_header(1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h0F, 1'b0);

        // zero snps: data ignored straight after the header
        settle();
        write_config(NumIndW'(7), '0);
        send_header(1'b1);
        send_byte(8'h12, 1'b0);

        for (int sec = 0; sec < 3; sec++) begin
            settle();
            case (sec)
                0: begin
                    tx_idle_pct = 26;
                    rx_idle_pct = 58;
                end
                1: begin
                    tx_idle_pct = 58;
                    rx_idle_pct = 26;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            item_budget = SectionItems;
            if (sec == 0) begin
                write_config('1, '1);
                send_header(1'b1);
                repeat (24) send_byte(8'($urandom_range(255)), 1'b0);
                item_budget -= 27;
            end else if (sec == 2) begin
                // long result stall while bytes keep coming, so the input backs up
                write_config(NumIndW'(9), NumSnpW'(4));
                hold_off_req = 1;
                send_header(1'b1);
                repeat (36) send_byte(8'($urandom_range(255)), 1'b0);
                item_budget -= 39;
            end
            while (item_budget > 0) begin
                settle();
                if ($urandom_range(9) == 0) write_config(NumIndW'(1), NumSnpW'(1));
                else if ($urandom_range(9) == 0)
                    write_config(NumIndW'($urandom_range(200, 13)), NumSnpW'($urandom_range(2, 1)));
                else
                    write_config(NumIndW'($urandom_range(12, 1)), NumSnpW'($urandom_range(4, 1)));
                repeat ($urandom_range(3, 1)) random_file();
            end
        end

        settle();
        if (fail_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
